[hdl/wcm_pkg.sv]
package wcm_pkg;

   // defaults for the top-level parameters
   localparam int PATTERN_MAX_DEF   = 32;
   localparam int CAPTURE_DEPTH_DEF = 63;
   localparam int POSITION_BITS_DEF = 16;

   localparam int CHAR_REGS   = 4;
   localparam int CHARS_TOTAL = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 6;
   localparam int START_W     = 16;
   localparam int END_W       = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CHARS_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START   = 3'd5;

   localparam logic [LEN_W-1:0] LENGTH_RESET = 6'd1;

   localparam logic [7:0] MARK_SKIP = 8'h2A;  // '*'
   localparam logic [7:0] MARK_COPY = 8'h40;  // '@'

   typedef enum logic [1:0] {
      KIND_CAPTURE = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_MISS    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_FETCH,
      ST_PUSH,
      ST_DONE,
      ST_MISS
   } wcm_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fetch;
      logic push_cap;
      logic push_done;
      logic push_miss;
   } wcm_cmd_type;

   typedef struct packed {
      logic loop_done;
      logic match;
      logic miss;
      logic count_zero;
      logic emit_last;
      logic out_free;
   } wcm_stat_type;

endpackage

[hdl/wcm_ctrl.sv]
module wcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  wcm_pkg::wcm_stat_type stat,
   output wcm_pkg::wcm_cmd_type  cmd
);
   import wcm_pkg::*;

   wcm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (stat.loop_done) begin
               if (stat.match) begin
                  state_in = stat.count_zero ? ST_DONE : ST_FETCH;
               end else if (stat.miss) begin
                  state_in = ST_MISS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            if (stat.out_free) begin
               cmd.push_cap = 1'b1;
               state_in     = stat.emit_last ? ST_DONE : ST_FETCH;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.push_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (stat.out_free) begin
               cmd.push_miss = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_steps: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_STEP))
      else $error("accepted beat not followed by a match step");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_cap || cmd.push_done || cmd.push_miss) |-> stat.out_free)
      else $error("result pushed while output register busy");

endmodule

[hdl/wcm_dp.sv]
module wcm_dp #(
   parameter int PATTERN_MAX   = wcm_pkg::PATTERN_MAX_DEF,
   parameter int CAPTURE_DEPTH = wcm_pkg::CAPTURE_DEPTH_DEF,
   parameter int POSITION_BITS = wcm_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  wcm_pkg::wcm_cmd_type            cmd,
   output wcm_pkg::wcm_stat_type           stat,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [wcm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import wcm_pkg::*;

   localparam int IDXW = $clog2(PATTERN_MAX + 1);
   localparam int CNTW = $clog2(CAPTURE_DEPTH + 1);
   localparam int CAW  = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
   localparam logic [IDXW-1:0] LEN_MAX = IDXW'(PATTERN_MAX);
   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(CAPTURE_DEPTH);

   // configuration
   logic [CSR_DATA_W-1:0] chars_ff [CHAR_REGS];
   logic [CSR_DATA_W-1:0] chars_in [CHAR_REGS];
   logic [LEN_W-1:0]      plen_ff, plen_in;
   logic [START_W-1:0]    start_ff, start_in;

   // match state
   logic [7:0]               ch_ff, ch_in;
   logic                     last_ff, last_in;
   logic [IDXW-1:0]          idx_ff, idx_in;
   logic                     skip_ff, skip_in;
   logic                     copy_ff, copy_in;
   logic                     fin_ff, fin_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] endp_ff, endp_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic                     ovf_ff, ovf_in;
   logic [CNTW-1:0]          emit_ff, emit_in;

   // capture memory
   logic [7:0] cap_mem [CAPTURE_DEPTH];
   logic [7:0] rd_data_ff;

   // output register
   logic             ovalid_ff, ovalid_in;
   kind_type         okind_ff, okind_in;
   logic [7:0]       ocap_ff, ocap_in;
   logic [END_W-1:0] oend_ff, oend_in;
   logic             otrunc_ff, otrunc_in;
   logic             olast_ff, olast_in;

   // step results
   logic [7:0]          pat_bytes [CHARS_TOTAL];
   logic [7:0]          pch;
   logic [IDXW-1:0]     len;
   logic                in_range;
   logic [IDXW-1:0]     idx_nx;
   logic                skip_nx, copy_nx, ovf_nx, consumed, cap_wr;
   logic [CNTW-1:0]     cnt_nx;
   logic                loop_done, match;
   logic [POSITION_BITS-1:0] pos_inc;
   logic                out_free, do_rearm;

   always_comb begin
      for (int i = 0; i < CHARS_TOTAL; i++) begin
         pat_bytes[i] = chars_ff[i >> 3][(i & 7) * 8 +: 8];
      end
   end

   assign len      = (plen_ff > LEN_W'(PATTERN_MAX)) ? LEN_MAX : IDXW'(plen_ff);
   assign pch      = pat_bytes[5'(idx_ff)];
   assign in_range = idx_ff < len;
   assign pos_inc  = (&pos_ff) ? pos_ff : pos_ff + 1'b1;
   assign out_free = !ovalid_ff || rsp_tready;

   // one sub-step of the pattern walk
   always_comb begin
      idx_nx   = idx_ff;
      skip_nx  = skip_ff;
      copy_nx  = copy_ff;
      cnt_nx   = cnt_ff;
      ovf_nx   = ovf_ff;
      consumed = 1'b0;
      cap_wr   = 1'b0;
      if (in_range) begin
         if (pch == MARK_SKIP) begin
            skip_nx = 1'b1;
            idx_nx  = IDXW'(idx_ff + 1'b1);
         end else if (pch == MARK_COPY) begin
            copy_nx = 1'b1;
            idx_nx  = IDXW'(idx_ff + 1'b1);
         end else if (skip_ff) begin
            if (ch_ff == pch) begin
               skip_nx = 1'b0;
            end else begin
               consumed = 1'b1;
            end
         end else if (copy_ff) begin
            if (ch_ff == pch) begin
               copy_nx = 1'b0;
            end else begin
               consumed = 1'b1;
               if (cnt_ff < CNT_MAX) begin
                  cap_wr = 1'b1;
                  cnt_nx = CNTW'(cnt_ff + 1'b1);
               end else begin
                  ovf_nx = 1'b1;
               end
            end
         end else if (ch_ff == pch) begin
            idx_nx   = IDXW'(idx_ff + 1'b1);
            consumed = 1'b1;
         end else if (idx_ff == '0) begin
            consumed = 1'b1;
         end else begin
            // restart: same byte is looked at again from the pattern head
            idx_nx = '0;
            cnt_nx = '0;
            ovf_nx = 1'b0;
         end
      end
   end

   assign loop_done = fin_ff || consumed || !(idx_nx < len);
   assign match     = !fin_ff && !(idx_nx < len);

   always_comb begin
      stat.loop_done  = loop_done;
      stat.match      = match;
      stat.miss       = loop_done && !fin_ff && !match && last_ff;
      stat.count_zero = (cnt_ff == '0);
      stat.emit_last  = (CNTW'(emit_ff + 1'b1) == cnt_ff);
      stat.out_free   = out_free;
   end

   always_comb begin
      chars_in  = chars_ff;
      plen_in   = plen_ff;
      start_in  = start_ff;
      ch_in     = ch_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      skip_in   = skip_ff;
      copy_in   = copy_ff;
      fin_in    = fin_ff;
      pos_in    = pos_ff;
      endp_in   = endp_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      emit_in   = emit_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      okind_in  = okind_ff;
      ocap_in   = ocap_ff;
      oend_in   = oend_ff;
      otrunc_in = otrunc_ff;
      olast_in  = olast_ff;
      do_rearm  = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_CHARS_A: chars_in[0] = csr_wr_data;
            REG_CHARS_B: chars_in[1] = csr_wr_data;
            REG_CHARS_C: chars_in[2] = csr_wr_data;
            REG_CHARS_D: chars_in[3] = csr_wr_data;
            REG_LENGTH:  plen_in     = csr_wr_data[LEN_W-1:0];
            REG_START: begin
               start_in = csr_wr_data[START_W-1:0];
               pos_in   = POSITION_BITS'(csr_wr_data[START_W-1:0]);
            end
            default: ;
         endcase
      end

      if (cmd.load) begin
         ch_in   = req_tdata;
         last_in = req_tlast;
         emit_in = '0;
      end

      if (cmd.step) begin
         if (fin_ff) begin
            do_rearm = last_ff;
         end else begin
            idx_in  = idx_nx;
            skip_in = skip_nx;
            copy_in = copy_nx;
            cnt_in  = cnt_nx;
            ovf_in  = ovf_nx;
            if (loop_done) begin
               pos_in  = pos_inc;
               endp_in = consumed ? pos_inc : pos_ff;
            end
         end
      end

      if (cmd.push_cap) begin
         ovalid_in = 1'b1;
         okind_in  = KIND_CAPTURE;
         ocap_in   = rd_data_ff;
         oend_in   = '0;
         otrunc_in = 1'b0;
         olast_in  = 1'b0;
         emit_in   = CNTW'(emit_ff + 1'b1);
      end

      if (cmd.push_done) begin
         ovalid_in = 1'b1;
         okind_in  = KIND_DONE;
         ocap_in   = '0;
         oend_in   = END_W'(endp_ff);
         otrunc_in = ovf_ff;
         olast_in  = 1'b1;
         if (last_ff) begin
            do_rearm = 1'b1;
         end else begin
            fin_in = 1'b1;
         end
      end

      if (cmd.push_miss) begin
         ovalid_in = 1'b1;
         okind_in  = KIND_MISS;
         ocap_in   = '0;
         oend_in   = '0;
         otrunc_in = 1'b0;
         olast_in  = 1'b1;
         do_rearm  = 1'b1;
      end

      if (do_rearm) begin
         idx_in  = '0;
         skip_in = 1'b0;
         copy_in = 1'b0;
         fin_in  = 1'b0;
         pos_in  = POSITION_BITS'(start_ff);
         cnt_in  = '0;
         ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAR_REGS; i++) begin
            chars_ff[i] <= '0;
         end
         plen_ff   <= LENGTH_RESET;
         start_ff  <= '0;
         last_ff   <= 1'b0;
         idx_ff    <= '0;
         skip_ff   <= 1'b0;
         copy_ff   <= 1'b0;
         fin_ff    <= 1'b0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         emit_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         chars_ff  <= chars_in;
         plen_ff   <= plen_in;
         start_ff  <= start_in;
         last_ff   <= last_in;
         idx_ff    <= idx_in;
         skip_ff   <= skip_in;
         copy_ff   <= copy_in;
         fin_ff    <= fin_in;
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         emit_ff   <= emit_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      endp_ff   <= endp_in;
      okind_ff  <= okind_in;
      ocap_ff   <= ocap_in;
      oend_ff   <= oend_in;
      otrunc_ff <= otrunc_in;
      olast_ff  <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.step && !fin_ff && cap_wr) begin
         cap_mem[cnt_ff[CAW-1:0]] <= ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff <= cap_mem[emit_ff[CAW-1:0]];
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {7'b0, otrunc_ff, oend_ff, ocap_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("capture count beyond buffer depth");

   a_capture_not_last: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && okind_ff == KIND_CAPTURE) |-> !olast_ff)
      else $error("captured byte flagged as end of run");

   a_done_settles: assert property (@(posedge clock) disable iff (reset)
      cmd.push_done |=> (fin_ff || (idx_ff == '0 && cnt_ff == '0)))
      else $error("done result neither finished nor rearmed");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (emit_ff < cnt_ff))
      else $error("capture read past fill count");

endmodule

[hdl/wildcard_capture_matcher.sv]
// channel   dir  beat fields (tdata low bit up / tuser / tlast)
// req_      in   tdata: text_byte[7:0]; tlast: final_byte
// rsp_      out  tdata: captured[7:0], end_position[23:8], truncated[24];
//                tuser: kind; tlast: run_end
// csr_      in   wr_en, index (0..5), wr_data (64b); no read-back
//
// Sequence: the IDLE state takes a byte, then the STEP state runs the pattern
//   sub-steps (a plain literal is one step; each marker and each restart adds
//   one). A match then runs FETCH (capture RAM read) and PUSH (output load)
//   for each captured byte, then DONE for the done beat.
// Reset: synchronous; clears control and config; capture RAM keeps contents.
// Stalls: rsp_tready low holds the output register and the sequencer waits.
module wildcard_capture_matcher #(
   parameter int PATTERN_MAX   = wcm_pkg::PATTERN_MAX_DEF,
   parameter int CAPTURE_DEPTH = wcm_pkg::CAPTURE_DEPTH_DEF,
   parameter int POSITION_BITS = wcm_pkg::POSITION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // text_byte
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wcm_pkg::RSP_DATA_W-1:0] rsp_tdata,   // captured, end_position, truncated
   output logic [1:0]                     rsp_tuser,   // kind
   output logic                           rsp_tlast
);
   import wcm_pkg::*;

   wcm_cmd_type  cmd;
   wcm_stat_type stat;

   wcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wcm_dp #(
      .PATTERN_MAX   (PATTERN_MAX),
      .CAPTURE_DEPTH (CAPTURE_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[dv/wcm_checker.sv]
module wcm_checker #(
   parameter int PATTERN_MAX   = wcm_pkg::PATTERN_MAX_DEF,
   parameter int CAPTURE_DEPTH = wcm_pkg::CAPTURE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // text_byte
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wcm_pkg::RSP_DATA_W-1:0] rsp_tdata,   // captured, end_position, truncated
   input  logic [1:0]                     rsp_tuser,   // kind
   input  logic                           rsp_tlast,
   output int                             fail_count,
   output int                             pending,
   output int                             beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import wcm_pkg::*;

   localparam logic [15:0] POS_TOP       = 16'hFFFF;
   localparam int          SUBSTEP_LIMIT = 4 * PATTERN_MAX + 8;
   localparam int          PRINT_CAP     = 40;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  captured;
      logic [15:0] end_pos;
      logic        truncated;
      logic        run_end;
   } result_beat_type;

   // search configuration and state, mirrored from what the csr port and req side saw
   logic [CSR_DATA_W-1:0] pat_words [CHAR_REGS];
   logic [LEN_W-1:0]      pat_len;
   logic [START_W-1:0]    first_pos;
   int unsigned           pat_idx;
   logic                  skipping;
   logic                  copying;
   logic                  matched;
   logic [15:0]           cur_pos;
   logic [7:0]            cap_buf [CAPTURE_DEPTH];
   int unsigned           cap_cnt;
   logic                  cap_lost;

   result_beat_type owed_beats [$];
   int mismatches = 0;
   int checked    = 0;

   function automatic logic [15:0] bump(logic [15:0] p);
      return (p == POS_TOP) ? p : p + 16'd1;
   endfunction

   function automatic logic [7:0] pat_char(int unsigned i);
      return pat_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic void rearm_search();
      pat_idx  = 0;
      skipping = 1'b0;
      copying  = 1'b0;
      matched  = 1'b0;
      cur_pos  = first_pos;
      cap_cnt  = 0;
      cap_lost = 1'b0;
   endfunction

   function automatic void owe(kind_type kind, logic [7:0] cap, logic [15:0] endp,
                               logic trunc, logic last);
      result_beat_type b;
      b.kind      = kind;
      b.captured  = cap;
      b.end_pos   = endp;
      b.truncated = trunc;
      b.run_end   = last;
      owed_beats.insert(owed_beats.size(), b);
   endfunction

   function automatic void match_byte(logic [7:0] ch, logic fin);
      int unsigned len;
      int unsigned steps;
      int unsigned k;
      logic [15:0] here;
      logic [7:0]  pc;
      logic        took;
      len   = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
      here  = cur_pos;
      took  = 1'b0;
      steps = 0;
      if (matched) begin
         if (fin) rearm_search();
         return;
      end
      while (!took && pat_idx < len) begin
         pc = pat_char(pat_idx);
         steps++;
         if (steps > SUBSTEP_LIMIT) begin
            took = 1'b1;
         end else if (pc == MARK_SKIP) begin
            skipping = 1'b1;
            pat_idx++;
         end else if (pc == MARK_COPY) begin
            copying = 1'b1;
            pat_idx++;
         end else if (skipping) begin
            // '*' wins over '@' while both are pending
            if (ch == pc) skipping = 1'b0;
            else took = 1'b1;
         end else if (copying) begin
            if (ch == pc) begin
               copying = 1'b0;
            end else begin
               if (cap_cnt < CAPTURE_DEPTH) begin
                  cap_buf[cap_cnt] = ch;
                  cap_cnt++;
               end else begin
                  cap_lost = 1'b1;
               end
               took = 1'b1;
            end
         end else if (ch == pc) begin
            pat_idx++;
            took = 1'b1;
         end else if (pat_idx == 0) begin
            took = 1'b1;
         end else begin
            // restart: drop the partial capture, look at the same byte again
            pat_idx  = 0;
            cap_cnt  = 0;
            cap_lost = 1'b0;
         end
      end
      cur_pos = bump(here);
      if (pat_idx >= len) begin
         for (k = 0; k < cap_cnt; k++) owe(KIND_CAPTURE, cap_buf[k], 16'd0, 1'b0, 1'b0);
         // trailing markers complete on a byte they do not consume
         owe(KIND_DONE, 8'd0, took ? bump(here) : here, cap_lost, 1'b1);
         if (fin) rearm_search();
         else matched = 1'b1;
      end else if (fin) begin
         owe(KIND_MISS, 8'd0, 16'd0, 1'b0, 1'b1);
         rearm_search();
      end
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (mismatches < PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      result_beat_type want;
      if (reset) begin
         foreach (pat_words[i]) pat_words[i] = '0;
         pat_len   = LENGTH_RESET;
         first_pos = '0;
         rearm_search();
         owed_beats.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_CHARS_A, REG_CHARS_B, REG_CHARS_C, REG_CHARS_D: begin
                  pat_words[csr_index - REG_CHARS_A] = csr_wr_data;
               end
               REG_LENGTH: begin
                  pat_len = csr_wr_data[LEN_W-1:0];
               end
               REG_START: begin
                  first_pos = csr_wr_data[START_W-1:0];
                  cur_pos   = first_pos;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) match_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_beats.size() == 0) begin
               if (mismatches < PRINT_CAP)
                  $display("%0t: result beat, expected none, got kind %0d data %h last %b",
                           $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = owed_beats.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("captured", 32'(want.captured), 32'(rsp_tdata[7:0]));
               check_field("end_position", 32'(want.end_pos), 32'(rsp_tdata[23:8]));
               check_field("truncated", 32'(want.truncated), 32'(rsp_tdata[24]));
               check_field("pad", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:25]));
               check_field("run_end", 32'(want.run_end), 32'(rsp_tlast));
               checked++;
            end
         end
      end
      fail_count    <= mismatches;
      pending       <= owed_beats.size();
      beats_checked <= checked;
   end

endmodule

[dv/wildcard_capture_matcher_tb.sv]
module wildcard_capture_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcm_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 2000;
   localparam int ITEM_TARGET   = 250;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // text_byte
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // captured, end_position, truncated
   logic [1:0]            rsp_tuser;   // kind
   logic                  rsp_tlast;

   int fail_count;
   int pending;
   int beats_checked;

   // stimulus-side copy of the pattern, used to load the pattern registers and to build texts
   logic [7:0] pat [CHARS_TOTAL];
   int         cur_len;

   bit quiet;
   bit send_gaps;
   bit sink_gaps;
   bit hold_off;
   bit hold_done;
   int cycle_count;
   int bytes_sent;
   int texts_sent;
   int setups;
   int rand_goal;

   wildcard_capture_matcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   wcm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .beats_checked (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("wildcard_capture_matcher_tb: errors");
      $finish;
   end

   // result sink: random stall bursts, plus one long hold-off on request
   initial begin : sink
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (sink_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic load_setup(input int len, input logic [15:0] start);
      int g;
      int i;
      logic [CSR_DATA_W-1:0] word;
      for (g = 0; g < CHAR_REGS; g++) begin
         for (i = 0; i < 8; i++) word[i*8 +: 8] = pat[g*8 + i];
         write_reg(CSR_IDX_W'(REG_CHARS_A + g), word);
      end
      write_reg(REG_LENGTH, CSR_DATA_W'(len));
      write_reg(REG_START, CSR_DATA_W'(start));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur_len = len;
      setups++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input logic [7:0] txt[$]);
      int i;
      for (i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
      texts_sent++;
   endtask

   task automatic send_string(input string s);
      logic [7:0] txt[$];
      int i;
      for (i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      send_text(txt);
   endtask

   // wait until every owed beat is back, then let result-less work finish
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic scramble_pattern();
      int i;
      for (i = 0; i < CHARS_TOTAL; i++) pat[i] = 8'($urandom_range(0, 255));
   endtask

   task automatic set_pattern_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) pat[i] = s[i];
   endtask

   function automatic logic [7:0] any_byte();
      int r;
      r = $urandom_range(0, 5);
      if (r < 2) return "a" + 8'($urandom_range(0, 3));
      if (r == 2) return $urandom_range(0, 1) ? MARK_SKIP : MARK_COPY;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic new_setup();
      int i;
      int r;
      int len;
      logic [15:0] start;
      for (i = 0; i < CHARS_TOTAL; i++) begin
         r = $urandom_range(0, 9);
         if (r < 2) pat[i] = MARK_SKIP;
         else if (r < 4) pat[i] = MARK_COPY;
         else if (r == 4) pat[i] = 8'($urandom_range(0, 255));
         else pat[i] = "a" + 8'($urandom_range(0, 3));
      end
      r = $urandom_range(0, 19);
      if (r == 0) len = 0;
      else if (r == 1) len = $urandom_range(33, 63);
      else if (r == 2) len = CHARS_TOTAL;
      else if (r < 6) len = $urandom_range(9, 31);
      else len = $urandom_range(1, 8);
      r = $urandom_range(0, 7);
      if (r == 0) start = 16'hFFFF - 16'($urandom_range(0, 6));
      else if (r == 1) start = 16'd0;
      else start = 16'($urandom_range(0, 65535));
      load_setup(len, start);
   endtask

   // mostly texts laid out along the pattern, some broken, some pure noise
   task automatic random_text();
      logic [7:0] txt[$];
      int i;
      int n;
      int eff;
      int style;
      eff   = (cur_len > CHARS_TOTAL) ? CHARS_TOTAL : cur_len;
      style = $urandom_range(0, 9);
      repeat ($urandom_range(0, 3)) txt.insert(txt.size(), any_byte());
      if (style == 0) begin
         repeat ($urandom_range(1, 8)) txt.insert(txt.size(), any_byte());
      end else begin
         for (i = 0; i < eff; i++) begin
            if (pat[i] == MARK_SKIP) begin
               repeat ($urandom_range(0, 3)) txt.insert(txt.size(), any_byte());
            end else if (pat[i] == MARK_COPY) begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
               repeat (n) txt.insert(txt.size(), any_byte());
            end else begin
               txt.insert(txt.size(), pat[i]);
            end
         end
         if (style == 1 && txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = any_byte();
         if (style == 2 && txt.size() > 1) void'(txt.pop_back());
      end
      repeat ($urandom_range(0, 2)) txt.insert(txt.size(), any_byte());
      if (txt.size() == 0) txt.insert(txt.size(), any_byte());
      send_text(txt);
   endtask

   initial begin : stimulus
      logic [7:0] txt[$];
      int i;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= REG_CHARS_A;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'd0;
      req_tlast   <= 1'b0;
      quiet       = 1'b0;
      send_gaps   = 1'b1;
      sink_gaps   = 1'b1;
      hold_off    = 1'b0;
      bytes_sent  = 0;
      texts_sent  = 0;
      setups      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset pattern is a single NUL: miss, hit, then a final byte after the hit
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      drain();

      // restart, capture, trailing '*', saturated positions
      scramble_pattern();
      set_pattern_text("ab@c*");
      load_setup(5, 16'hFFFD);
      send_string("aabXcZq");
      drain();

      // empty pattern completes on the byte it sees
      load_setup(0, 16'd0);
      send_string("~");
      drain();

      // '*' and '@' both pending: skip wins, nothing captured
      scramble_pattern();
      set_pattern_text("*@c");
      load_setup(3, 16'd100);
      send_string("xyc");
      drain();

      // over-long length clamps; a pattern of only markers
      for (i = 0; i < CHARS_TOTAL; i++) pat[i] = (i % 2) ? MARK_COPY : MARK_SKIP;
      load_setup(63, 16'd7);
      send_byte(8'hA5, 1'b1);
      drain();

      rand_goal = ITEM_TARGET;

      // capture overflow with the sink held off, so the block backs up its input
      scramble_pattern();
      set_pattern_text("x@y");
      load_setup(3, 16'd200);
      hold_off = 1'b1;
      txt.insert(txt.size(), "x");
      repeat (70) txt.insert(txt.size(), "a" + 8'($urandom_range(0, 3)));
      txt.insert(txt.size(), "y");
      txt.insert(txt.size(), "e");
      send_text(txt);
      send_string("xaay");
      drain();

      while (bytes_sent < rand_goal) begin
         if (bytes_sent > rand_goal - 50) quiet = 1'b1;
         send_gaps = $urandom_range(0, 3) != 0;
         sink_gaps = $urandom_range(0, 3) != 0;
         new_setup();
         repeat ($urandom_range(1, 4)) random_text();
         drain();
      end

      $display("covered %0d text bytes in %0d texts across %0d pattern setups",
               bytes_sent, texts_sent, setups);
      $display("%0d result beats compared, incl. restarts, overflow and position saturation",
               beats_checked);
      if (fail_count == 0) begin
         $display("wildcard_capture_matcher_tb: clean");
      end else begin
         $display("wildcard_capture_matcher_tb: errors");
      end
      $finish;
   end

endmodule
